// ----- hdl/dbha_pkg.sv -----
// ----------------------------------------------------------------------------
// DMA buffer handle allocator package
// Shared constants, request codes, sequencer states and the control bundle
// between the sequencer and the slot table.
// ----------------------------------------------------------------------------
package dbha_pkg;

   localparam int SLOTS_DEF      = 32;
   localparam int ALIGN_LOG2_DEF = 12;

   localparam int ADDR_W   = 48;
   localparam int SIZE_W   = 32;
   localparam int HANDLE_W = 6;
   localparam int NEWH_W   = 5;
   localparam int KIND_W   = 2;
   localparam int CSR_W    = 64;
   localparam int PADDR_W  = 4;

   // slots examined by the scan in one cycle
   localparam int SCAN_LANES = 8;

   localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MAP     = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ROUND,
      ST_FIT,
      ST_SCAN,
      ST_PLACE,
      ST_READ,
      ST_RESP
   } dbha_state_type;

   typedef struct packed {
      logic scan_clear;
      logic scan_step;
      logic place;
      logic set_used;
      logic release_slot;
      logic read;
   } dbha_tbl_cmd_type;

   typedef struct packed {
      logic hit;
      logic last_group;
      logic used;
   } dbha_tbl_stat_type;

endpackage

// ----- hdl/dbha_slot_table.sv -----
// ----------------------------------------------------------------------------
// DMA buffer handle allocator slot table
// Slot occupancy flags, the buffer address memory and the lowest-free-slot
// scan, which looks at one group of slots per cycle.
// ----------------------------------------------------------------------------
module dbha_slot_table import dbha_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF,
   parameter int IW    = $clog2(SLOTS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dbha_tbl_cmd_type       cmd,
   input  logic [IW-1:0]          idx,
   input  logic [ADDR_W-1:0]      wr_addr,
   output dbha_tbl_stat_type      stat,
   output logic [IW-1:0]          hit_idx,
   output logic [ADDR_W-1:0]      rd_addr
);

   localparam int NGROUPS = (SLOTS + SCAN_LANES - 1) / SCAN_LANES;
   localparam int GW      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
   localparam int LW      = $clog2(SCAN_LANES);
   localparam int FW      = GW + LW;
   localparam logic [FW:0]   SLOTS_F   = (FW + 1)'(SLOTS);
   localparam logic [GW-1:0] LAST_GRP  = GW'(NGROUPS - 1);

   logic [SLOTS-1:0]  used_ff, used_in;
   logic [GW-1:0]     grp_ff, grp_in;
   logic [ADDR_W-1:0] slot_addr_ff [SLOTS];
   logic [ADDR_W-1:0] rd_addr_ff;
   logic [FW-1:0]     cand;
   logic              hit;

   // lowest free slot within the current group
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      cand    = '0;
      for (int k = 0; k < SCAN_LANES; k++) begin
         cand = {grp_ff, LW'(k)};
         if (!hit && ({1'b0, cand} < SLOTS_F) && !used_ff[cand[IW-1:0]]) begin
            hit     = 1'b1;
            hit_idx = cand[IW-1:0];
         end
      end
   end

   always_comb begin
      stat.hit        = hit;
      stat.last_group = (grp_ff == LAST_GRP);
      stat.used       = used_ff[idx];
   end

   always_comb begin
      grp_in = grp_ff;
      if (cmd.scan_clear) begin
         grp_in = '0;
      end else if (cmd.scan_step) begin
         grp_in = grp_ff + GW'(1);
      end
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.place && cmd.set_used) begin
         used_in[idx] = 1'b1;
      end
      if (cmd.release_slot) begin
         used_in[idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         grp_ff  <= '0;
      end else begin
         used_ff <= used_in;
         grp_ff  <= grp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.place) begin
         slot_addr_ff[idx] <= wr_addr;
      end
      if (cmd.read) begin
         rd_addr_ff <= slot_addr_ff[idx];
      end
   end

   assign rd_addr = rd_addr_ff;

endmodule

// ----- hdl/dma_buffer_handle_allocator.sv -----
// ----------------------------------------------------------------------------
// DMA buffer handle allocator
// Bump allocator over a physical buffer pool with a table of buffer handles.
// ----------------------------------------------------------------------------
// One request at a time: busy rises at the edge that accepts start and falls
// when the result has been shown. Every request gives exactly one result,
// shown for one cycle with rsp_strobe high; the receiver must take it then.
// For a create, the lowest free slot is found by a scan over eight slots a
// cycle, and size rounding, the pool fit check and the buffer address all go
// through one shared 49-bit adder. The pool base and pool size registers sit
// at byte addresses 0 and 8 of the CSR port (64-bit data); the low address
// bits are ignored. Write them only while busy is low. Pool space is given
// back only by reset.
// ----------------------------------------------------------------------------
module dma_buffer_handle_allocator import dbha_pkg::*; #(
   parameter int SLOTS      = SLOTS_DEF,
   parameter int ALIGN_LOG2 = ALIGN_LOG2_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 start,
   output logic                 busy,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [SIZE_W-1:0]    req_request_size,
   input  logic [HANDLE_W-1:0]  req_handle,
   input  logic                 req_task_present,
   // result channel
   output logic                 rsp_strobe,
   output logic                 rsp_status,
   output logic [NEWH_W-1:0]    rsp_new_handle,
   output logic [ADDR_W-1:0]    rsp_address,
   // configuration port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [PADDR_W-1:0]   paddr,
   input  logic [CSR_W-1:0]     pwdata,
   output logic [CSR_W-1:0]     prdata,
   output logic                 pready
);

   localparam int IW = $clog2(SLOTS);
   localparam logic [SIZE_W:0]  AMASK     = (33'd1 << ALIGN_LOG2) - 33'd1;
   localparam logic [IW-1:0]    LAST_SLOT = IW'(SLOTS - 1);

   dbha_state_type state_ff, state_in;

   logic [ADDR_W-1:0]   region_base_ff, region_bytes_ff, bytes_used_ff, bytes_used_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic                task_ff, task_in;
   logic [SIZE_W:0]     sz_ff, sz_in;
   logic [ADDR_W-1:0]   total_ff, total_in;
   logic [IW-1:0]       slot_ff, slot_in;
   logic                status_ff, status_in;
   logic [NEWH_W-1:0]   nh_ff, nh_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;

   logic                accept, csr_wr, in_range, map_ok, fit;
   logic [ADDR_W-1:0]   add_a, add_b;
   logic [ADDR_W:0]     add_sum;
   logic [HANDLE_W-1:0] hm1;
   logic [IW-1:0]       hslot, tbl_idx, hit_idx;
   logic [ADDR_W-1:0]   rd_addr;
   dbha_tbl_cmd_type    cmd;
   dbha_tbl_stat_type   stat;

   assign accept = start && !busy;
   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = paddr[3] ? CSR_W'(region_bytes_ff) : CSR_W'(region_base_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff  <= '0;
         region_bytes_ff <= '0;
      end else if (csr_wr) begin
         if (paddr[3]) begin
            region_bytes_ff <= pwdata[ADDR_W-1:0];
         end else begin
            region_base_ff <= pwdata[ADDR_W-1:0];
         end
      end
   end

   // shared adder: rounding, fit check, buffer address
   always_comb begin
      unique case (state_ff)
         ST_ROUND: begin
            add_a = ADDR_W'(size_ff);
            add_b = ADDR_W'(AMASK);
         end
         ST_FIT: begin
            add_a = bytes_used_ff;
            add_b = ADDR_W'(sz_ff);
         end
         ST_PLACE: begin
            add_a = region_base_ff;
            add_b = bytes_used_ff;
         end
         default: begin
            add_a = '0;
            add_b = '0;
         end
      endcase
   end

   assign add_sum = {1'b0, add_a} + {1'b0, add_b};
   assign fit     = add_sum <= {1'b0, region_bytes_ff};

   assign hm1      = handle_ff - HANDLE_W'(1);
   assign hslot    = IW'(hm1);
   assign in_range = 32'(handle_ff) < SLOTS;
   assign tbl_idx  = (state_ff == ST_PLACE) ? slot_ff : hslot;
   assign map_ok   = (handle_ff != '0) && in_range && stat.used && task_ff;

   dbha_slot_table #(
      .SLOTS (SLOTS),
      .IW    (IW)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .idx     (tbl_idx),
      .wr_addr (add_sum[ADDR_W-1:0]),
      .stat    (stat),
      .hit_idx (hit_idx),
      .rd_addr (rd_addr)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (kind_ff == KIND_CREATE) begin
               state_in = ST_ROUND;
            end else if (kind_ff == KIND_MAP && map_ok) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_ROUND: state_in = ST_FIT;
         ST_FIT: begin
            state_in = fit ? ST_SCAN : ST_RESP;
         end
         ST_SCAN: begin
            if (stat.hit) begin
               state_in = ST_PLACE;
            end else if (stat.last_group) begin
               state_in = ST_RESP;
            end
         end
         ST_PLACE: state_in = ST_RESP;
         ST_READ:  state_in = ST_RESP;
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      cmd           = '0;
      kind_in       = kind_ff;
      size_in       = size_ff;
      handle_in     = handle_ff;
      task_in       = task_ff;
      sz_in         = sz_ff;
      total_in      = total_ff;
      slot_in       = slot_ff;
      bytes_used_in = bytes_used_ff;
      status_in     = status_ff;
      nh_in         = nh_ff;
      addr_in       = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in   = req_kind;
               size_in   = req_request_size;
               handle_in = req_handle;
               task_in   = req_task_present;
               status_in = STATUS_FAIL;
               nh_in     = '0;
               addr_in   = '0;
            end
         end
         ST_DECODE: begin
            if (kind_ff == KIND_DESTROY && in_range) begin
               status_in        = STATUS_OK;
               cmd.release_slot = (handle_ff != '0);
            end
            if (kind_ff == KIND_MAP && map_ok) begin
               cmd.read = 1'b1;
            end
         end
         ST_ROUND: begin
            sz_in = add_sum[SIZE_W:0] & ~AMASK;
         end
         ST_FIT: begin
            total_in       = add_sum[ADDR_W-1:0];
            cmd.scan_clear = fit;
         end
         ST_SCAN: begin
            if (stat.hit) begin
               slot_in = hit_idx;
            end else if (!stat.last_group) begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_PLACE: begin
            // the last slot would hand out handle SLOTS: drop it, keep the space
            cmd.place     = 1'b1;
            bytes_used_in = total_ff;
            if (slot_ff != LAST_SLOT) begin
               cmd.set_used = 1'b1;
               status_in    = STATUS_OK;
               nh_in        = NEWH_W'(32'(slot_ff) + 1);
            end
         end
         ST_READ: begin
            addr_in   = rd_addr;
            status_in = STATUS_OK;
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bytes_used_ff <= '0;
      end else begin
         state_ff      <= state_in;
         bytes_used_ff <= bytes_used_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      size_ff   <= size_in;
      handle_ff <= handle_in;
      task_ff   <= task_in;
      sz_ff     <= sz_in;
      total_ff  <= total_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      nh_ff     <= nh_in;
      addr_ff   <= addr_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = (state_ff == ST_RESP);
   assign rsp_status     = status_ff;
   assign rsp_new_handle = nh_ff;
   assign rsp_address    = addr_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe lasted more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !rsp_strobe)
      else $error("accepted request did not raise busy");

   a_result_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_new_handle != '0) |-> (rsp_status == STATUS_OK)
                                               && (rsp_address == '0))
      else $error("granted handle with failure status or address");

   a_place_from_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLACE) |-> $past(state_ff) == ST_SCAN && $past(stat.hit))
      else $error("slot placed without a scan hit");

endmodule

// ----- tb/dma_buffer_handle_allocator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DMA buffer handle allocator testbench
// Drives create, destroy and map requests through the start/busy handshake,
// reprograms the pool registers between bursts and checks every result
// strobe against a cycle-free model of the slot table and the bump pointer.
// ----------------------------------------------------------------------------
module dma_buffer_handle_allocator_tb import dbha_pkg::*; ();

   localparam int SLOTS       = SLOTS_DEF;
   localparam int ALIGN_LOG2  = ALIGN_LOG2_DEF;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 206;

   localparam logic [KIND_W-1:0]  KIND_UNUSED      = 2'd3;
   localparam logic [PADDR_W-1:0] REG_REGION_BASE  = PADDR_W'(0);
   localparam logic [PADDR_W-1:0] REG_REGION_BYTES = PADDR_W'(8);

   localparam logic [63:0] ALIGN_MASK = (64'd1 << ALIGN_LOG2) - 64'd1;

   typedef struct packed {
      logic              status;
      logic [NEWH_W-1:0] new_handle;
      logic [ADDR_W-1:0] address;
   } outcome_type;

   class allocator_scoreboard;
      bit                slot_used [SLOTS];
      logic [ADDR_W-1:0] slot_addr [SLOTS];
      logic [ADDR_W-1:0] bytes_used;
      logic [ADDR_W-1:0] region_base;
      logic [ADDR_W-1:0] region_bytes;
      outcome_type       pending [$];
      int                failures;

      function new();
         bytes_used   = '0;
         region_base  = '0;
         region_bytes = '0;
         failures     = 0;
         foreach (slot_used[i]) slot_used[i] = 1'b0;
      endfunction

      task report(string msg);
         if (failures < 40) $display("%0t: mismatch: %s", $time, msg);
         failures++;
      endtask

      function void set_register(logic [PADDR_W-1:0] addr, logic [CSR_W-1:0] data);
         if (addr == REG_REGION_BASE) region_base = data[ADDR_W-1:0];
         else if (addr == REG_REGION_BYTES) region_bytes = data[ADDR_W-1:0];
      endfunction

      // Work out the outcome of one accepted request and advance the table.
      function void note_request(logic [KIND_W-1:0] kind, logic [SIZE_W-1:0] size,
                                 logic [HANDLE_W-1:0] handle, logic has_task);
         outcome_type r;
         logic [63:0] rounded;
         int          free_slot;
         r.status     = STATUS_FAIL;
         r.new_handle = '0;
         r.address    = '0;
         free_slot    = -1;
         case (kind)
            KIND_CREATE: begin
               rounded = (64'(size) + ALIGN_MASK) & ~ALIGN_MASK;
               for (int i = SLOTS - 1; i >= 0; i--)
                  if (!slot_used[i]) free_slot = i;
               if (64'(bytes_used) + rounded <= 64'(region_bytes) && free_slot >= 0) begin
                  slot_addr[free_slot] = region_base + bytes_used;
                  bytes_used = bytes_used + rounded[ADDR_W-1:0];
                  // the top slot is taken and dropped again; its space stays consumed
                  if (free_slot + 1 < SLOTS) begin
                     slot_used[free_slot] = 1'b1;
                     r.status     = STATUS_OK;
                     r.new_handle = NEWH_W'(free_slot + 1);
                  end
               end
            end
            KIND_DESTROY: begin
               if (handle < SLOTS) begin
                  if (handle != 0) slot_used[handle - 1] = 1'b0;
                  r.status = STATUS_OK;
               end
            end
            KIND_MAP: begin
               if (handle != 0 && handle < SLOTS && has_task) begin
                  if (slot_used[handle - 1]) begin
                     r.status  = STATUS_OK;
                     r.address = slot_addr[handle - 1];
                  end
               end
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      task check_result(logic status, logic [NEWH_W-1:0] new_handle,
                        logic [ADDR_W-1:0] address);
         outcome_type exp;
         if (pending.size() == 0) begin
            report("result strobe with no request outstanding");
            return;
         end
         exp = pending.pop_front();
         if (status !== exp.status)
            report($sformatf("status %b, expected %b", status, exp.status));
         if (new_handle !== exp.new_handle)
            report($sformatf("new_handle %0d, expected %0d", new_handle, exp.new_handle));
         if (address !== exp.address)
            report($sformatf("address %h, expected %h", address, exp.address));
      endtask

      function logic [HANDLE_W-1:0] pick_bound_handle();
         int bound [$];
         foreach (slot_used[i])
            if (slot_used[i]) bound.push_back(i + 1);
         if (bound.size() == 0) return '0;
         return HANDLE_W'(bound[$urandom_range(bound.size() - 1)]);
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [KIND_W-1:0]   req_kind;
   logic [SIZE_W-1:0]   req_request_size;
   logic [HANDLE_W-1:0] req_handle;
   logic                req_task_present;
   logic                rsp_strobe;
   logic                rsp_status;
   logic [NEWH_W-1:0]   rsp_new_handle;
   logic [ADDR_W-1:0]   rsp_address;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [PADDR_W-1:0]  paddr;
   logic [CSR_W-1:0]    pwdata;
   logic [CSR_W-1:0]    prdata;
   logic                pready;

   allocator_scoreboard sb;
   bit                  quiet;
   int                  cycle_count;

   dma_buffer_handle_allocator u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_request_size (req_request_size),
      .req_handle       (req_handle),
      .req_task_present (req_task_present),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_new_handle   (rsp_new_handle),
      .rsp_address      (rsp_address),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("dma_buffer_handle_allocator_tb: FAIL");
         $finish;
      end
   end

   // Check before noting; no request is taken at the edge of a result, as busy is still high then.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_result(rsp_status, rsp_new_handle, rsp_address);
         if (start && !busy)
            sb.note_request(req_kind, req_request_size, req_handle, req_task_present);
      end
   end

   // Entered and left at a rising edge; start is left high for the next request.
   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [SIZE_W-1:0] size,
                               input logic [HANDLE_W-1:0] handle, input logic has_task);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(99) < 24) gap = $urandom_range(1, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_kind         <= kind;
      req_request_size <= size;
      req_handle       <= handle;
      req_task_present <= has_task;
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(negedge clock); while (busy || sb.pending.size() != 0);
      @(posedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic [PADDR_W-1:0] addr,
                             input logic [CSR_W-1:0] data);
      logic [ADDR_W-1:0] expected;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (is_write) begin
         sb.set_register(addr, data);
      end else begin
         expected = (addr == REG_REGION_BASE) ? sb.region_base : sb.region_bytes;
         if (prdata[ADDR_W-1:0] !== expected)
            sb.report($sformatf("register %0d reads %h, expected %h",
                                addr, prdata[ADDR_W-1:0], expected));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Upper data bits carry noise; the registers hold 48 bits only.
   task automatic reconfigure(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size);
      wait_idle();
      csr_access(1'b1, REG_REGION_BASE, {16'($urandom), base});
      csr_access(1'b1, REG_REGION_BYTES, {16'($urandom), size});
      csr_access(1'b0, REG_REGION_BASE, '0);
      csr_access(1'b0, REG_REGION_BYTES, '0);
   endtask

   task automatic random_request(input int create_weight);
      logic [KIND_W-1:0]   kind;
      logic [SIZE_W-1:0]   size;
      logic [HANDLE_W-1:0] handle;
      int                  pick;
      pick = $urandom_range(99);
      if (pick < create_weight) kind = KIND_CREATE;
      else if (pick < create_weight + (97 - create_weight) / 2) kind = KIND_DESTROY;
      else if (pick < 97) kind = KIND_MAP;
      else kind = KIND_UNUSED;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: size = 32'($urandom_range(0, 3 << ALIGN_LOG2));
         6: size = 32'(($urandom_range(0, 8) << ALIGN_LOG2) + $urandom_range(0, 2)) - 32'd1;
         7: size = '0;
         8: size = $urandom();
         default: size = $urandom() >> $urandom_range(0, 31);
      endcase
      case ($urandom_range(9))
         7: handle = HANDLE_W'($urandom_range(0, 63));
         8: handle = $urandom_range(1) ? HANDLE_W'(SLOTS - 1) : HANDLE_W'(SLOTS);
         9: handle = HANDLE_W'($urandom_range(0, SLOTS - 1));
         default: handle = sb.pick_bound_handle();
      endcase
      send_request(kind, size, handle, $urandom_range(99) < 85);
   endtask

   initial begin
      int                phase;
      int                create_weight;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] size;
      sb               = new();
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_kind         = KIND_CREATE;
      req_request_size = '0;
      req_handle       = '0;
      req_task_present = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      quiet            = 1'b0;
      cycle_count      = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty pool straight after reset: only a zero-byte create fits
      send_request(KIND_CREATE,  32'd0,        6'h3F, 1'b1);
      send_request(KIND_CREATE,  32'd1,        6'h00, 1'b0);
      send_request(KIND_MAP,     32'hFFFFFFFF, 6'd1,  1'b0);
      send_request(KIND_MAP,     32'd0,        6'd1,  1'b1);
      send_request(KIND_MAP,     32'd0,        6'd0,  1'b1);
      send_request(KIND_MAP,     32'd0,        6'h3F, 1'b1);
      send_request(KIND_MAP,     32'd0,        6'(SLOTS), 1'b1);
      send_request(KIND_DESTROY, 32'd0,        6'd1,  1'b1);
      send_request(KIND_DESTROY, 32'd0,        6'd1,  1'b1);
      send_request(KIND_DESTROY, 32'd0,        6'd0,  1'b0);
      send_request(KIND_DESTROY, 32'd0,        6'(SLOTS), 1'b1);
      send_request(KIND_DESTROY, 32'd0,        6'h3F, 1'b1);
      send_request(KIND_UNUSED,  32'd4096,     6'd1,  1'b1);

      // pool near the top of the address space: the second buffer wraps
      reconfigure(48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_FFFF);
      send_request(KIND_CREATE,  32'hFFFFFFFF, 6'd0,  1'b1);
      send_request(KIND_CREATE,  32'd4097,     6'd0,  1'b1);
      send_request(KIND_MAP,     32'd0,        6'd1,  1'b1);
      send_request(KIND_MAP,     32'd0,        6'd2,  1'b1);
      send_request(KIND_CREATE,  32'd4096,     6'd0,  1'b0);
      send_request(KIND_CREATE,  32'd0,        6'd0,  1'b1);
      send_request(KIND_CREATE,  32'd1,        6'd0,  1'b1);
      send_request(KIND_MAP,     32'd0,        6'd4,  1'b1);
      send_request(KIND_MAP,     32'd0,        6'd5,  1'b1);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         base = {16'($urandom), 32'($urandom)};
         size = 48'hFFFF_FFFF_FFFF;
         create_weight = 45;
         case (phase)
            1: begin
               base = '0;
               create_weight = 75;
            end
            2: begin
               base = 48'hFFFF_FFFF_F000 - 48'($urandom_range(0, 4) << ALIGN_LOG2);
               size = sb.bytes_used + 48'($urandom_range(0, 40) << ALIGN_LOG2);
               create_weight = 55;
            end
            3: begin
               base = 48'hFFFF_FFFF_FFFF;
               size = '0;
               create_weight = 35;
            end
            4: size = sb.bytes_used + 48'({$urandom_range(0, 3), 32'($urandom)});
            5: create_weight = 30;
            6: begin
               size = sb.bytes_used;
               create_weight = 60;
            end
            default: ;
         endcase
         reconfigure(base, size);
         // one long burst per phase; in phase 4 the sender never pauses
         quiet = (phase == 4);
         repeat (PHASE_ITEMS) random_request(create_weight);
      end

      quiet = 1'b0;
      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.pending.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending.size()));
      if (sb.failures == 0) begin
         $display("dma_buffer_handle_allocator_tb: PASS");
      end else begin
         $display("dma_buffer_handle_allocator_tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/dbha_pkg.sv
hdl/dbha_slot_table.sv
hdl/dma_buffer_handle_allocator.sv
tb/dma_buffer_handle_allocator_tb.sv
